[rtl/sliding_window_histogram_ccdf_core_macros.svh]
// ---------------------------------------------------------------------------
// assertion macros for the sliding window histogram core
// clocked property checks, with and without the reset disable
// ---------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_HISTOGRAM_CCDF_CORE_MACROS_SVH
`define SLIDING_WINDOW_HISTOGRAM_CCDF_CORE_MACROS_SVH

// checked outside reset only
`define SWHC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked at every edge, reset included
`define SWHC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[rtl/swhc_pkg.sv]
// ---------------------------------------------------------------------------
// swhc_pkg
// shared constants and codes of the sliding window histogram core
// ---------------------------------------------------------------------------
package swhc_pkg;

  localparam int BINS_DEF           = 64;
  localparam int WINDOW_PERIODS_DEF = 8;
  localparam int MAX_RESULTS        = 64;

  localparam int MODE_W   = 2;
  localparam int LEVEL_W  = 17;
  localparam int COL_W    = 6;
  localparam int ROW_W    = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int GRID_W   = 7;
  localparam int COUNT_W  = 16;

  localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TICK   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRIDLINE = 2'd2;

  localparam logic [ROW_W-1:0]  HEIGHT_RST   = 8'd219;
  localparam logic [GRID_W-1:0] GRIDLINE_RST = 7'd16;

endpackage

[rtl/swhc_if.sv]
// ---------------------------------------------------------------------------
// swhc channel interfaces
// valid/ready channels for input items and result items
// ---------------------------------------------------------------------------
interface swhc_in_if;
  logic                        valid;
  logic                        ready;
  logic [swhc_pkg::MODE_W-1:0]  mode;
  logic [swhc_pkg::LEVEL_W-1:0] sample_level;
  modport source (output valid, mode, sample_level, input ready);
  modport sink (input valid, mode, sample_level, output ready);
endinterface

interface swhc_out_if;
  logic                       valid;
  logic                       ready;
  logic [swhc_pkg::COL_W-1:0] column;
  logic [swhc_pkg::ROW_W-1:0] old_row;
  logic [swhc_pkg::ROW_W-1:0] new_row;
  logic                       last;
  modport source (output valid, column, old_row, new_row, last, input ready);
  modport sink (input valid, column, old_row, new_row, last, output ready);
endinterface

[rtl/swhc_ram.sv]
// ---------------------------------------------------------------------------
// swhc_ram
// generic single write, single read ram with registered read data
// ---------------------------------------------------------------------------
module swhc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/sliding_window_histogram_ccdf_core.sv]
// a sample reads and rewrites its bin count, a clear zeroes every count, and a tick
// sums all counts, computes each column's row, then zeroes the next period's counts,
// waiting on output stalls; one item at a time; the tick time is set by the single count
// memory read port and the shared 8 step restoring divider per column
// after reset a clearing pass zeroes both memories, no item is accepted meanwhile;
// configuration writes are taken at any time
// ---------------------------------------------------------------------------
// sliding_window_histogram_ccdf_core
// windowed histogram with ccdf plot row updates, sequenced over one ram port
// ---------------------------------------------------------------------------
`include "sliding_window_histogram_ccdf_core_macros.svh"

module sliding_window_histogram_ccdf_core #(
  parameter int BINS           = swhc_pkg::BINS_DEF,
  parameter int WINDOW_PERIODS = swhc_pkg::WINDOW_PERIODS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [swhc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [swhc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  swhc_in_if.sink                         in_i,
  swhc_out_if.source                      out_o
);

  localparam int NE  = BINS * WINDOW_PERIODS;
  localparam int AW  = $clog2(NE);
  localparam int IW  = $clog2(NE + 1);
  localparam int BW  = $clog2(BINS);
  localparam int BCW = $clog2(BINS + 1);
  localparam int PW  = (WINDOW_PERIODS > 1) ? $clog2(WINDOW_PERIODS) : 1;
  localparam int JW  = $clog2(WINDOW_PERIODS + 1);
  localparam int CW  = $clog2(NE) + swhc_pkg::COUNT_W;
  localparam int RW  = CW + swhc_pkg::ROW_W;
  localparam int PRW = swhc_pkg::LEVEL_W + $clog2(BINS + 1);
  localparam int NW  = $clog2(swhc_pkg::MAX_RESULTS + 1);
  localparam int CTW = swhc_pkg::COUNT_W;
  localparam int RWW = swhc_pkg::ROW_W;
  localparam int COW = swhc_pkg::COL_W;

  localparam logic [AW-1:0]  BINS_A   = AW'(BINS);
  localparam logic [IW-1:0]  NE_LAST  = IW'(NE - 1);
  localparam logic [BCW-1:0] BIN_LAST = BCW'(BINS - 1);
  localparam logic [JW-1:0]  PER_LAST = JW'(WINDOW_PERIODS - 1);
  localparam logic [PW-1:0]  PQ_LAST  = PW'(WINDOW_PERIODS - 1);
  localparam logic [NW-1:0]  N_MAX    = NW'(swhc_pkg::MAX_RESULTS);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_INIT    = 4'd1;
  localparam logic [3:0] ST_CLR     = 4'd2;
  localparam logic [3:0] ST_SMP_RD  = 4'd3;
  localparam logic [3:0] ST_SMP_WR  = 4'd4;
  localparam logic [3:0] ST_TOT_RD  = 4'd5;
  localparam logic [3:0] ST_TOT_ACC = 4'd6;
  localparam logic [3:0] ST_COL     = 4'd7;
  localparam logic [3:0] ST_DIV     = 4'd8;
  localparam logic [3:0] ST_SR_RD   = 4'd9;
  localparam logic [3:0] ST_SR_CMP  = 4'd10;
  localparam logic [3:0] ST_PUSH    = 4'd11;
  localparam logic [3:0] ST_PRE_RD  = 4'd12;
  localparam logic [3:0] ST_PRE_ACC = 4'd13;
  localparam logic [3:0] ST_FLUSH   = 4'd14;
  localparam logic [3:0] ST_PCLR    = 4'd15;

  logic [3:0] state_q, state_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [BCW-1:0] i_q, i_d;
  logic [JW-1:0] j_q, j_d;
  logic [2:0] k_q, k_d;
  logic [PW-1:0] per_q, per_d;
  logic [CW-1:0] acc_q, acc_d, total_q, total_d;
  logic [RW-1:0] rem_q, rem_d;
  logic [RWW-1:0] q_q, q_d, row_q, row_d, cur_old_q, cur_old_d;
  logic [swhc_pkg::GRID_W-1:0] gcnt_q, gcnt_d;
  logic [NW-1:0] n_q, n_d;
  logic [AW-1:0] addr_q, addr_d;
  logic pend_valid_q, pend_valid_d;
  logic [COW-1:0] pend_col_q, pend_col_d;
  logic [RWW-1:0] pend_old_q, pend_old_d, pend_new_q, pend_new_d;
  logic out_valid_q, out_valid_d, out_last_q, out_last_d;
  logic [COW-1:0] out_col_q, out_col_d;
  logic [RWW-1:0] out_old_q, out_old_d, out_new_q, out_new_d;
  logic en_q;
  logic [RWW-1:0] h_q;
  logic [swhc_pkg::GRID_W-1:0] gs_q;

  logic bin_we, sr_we;
  logic [AW-1:0] bin_waddr, bin_raddr;
  logic [CTW-1:0] bin_wdata, bin_rdata;
  logic [BW-1:0] sr_waddr;
  logic [RWW-1:0] sr_wdata, sr_rdata;

  logic in_acc, slot_free, grid, emit;
  logic [AW-1:0] per_base, pre_addr, pclr_addr;
  logic [PRW-1:0] lvl_prod, lvl_shift;
  logic [BW-1:0] smp_bin;
  logic [CW-1:0] suffix;
  logic [RW-1:0] dsh;
  logic [RWW-1:0] q_next;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && (state_q == ST_IDLE);
  assign slot_free  = !out_valid_q || out_o.ready;

  assign per_base  = AW'(per_q) * BINS_A;
  assign pre_addr  = AW'(j_q) * BINS_A + AW'(i_q[BW-1:0]);
  assign pclr_addr = per_base + AW'(i_q[BW-1:0]);
  assign lvl_prod  = PRW'(in_i.sample_level) * PRW'(BINS);
  assign lvl_shift = lvl_prod >> 16;
  assign smp_bin   = (lvl_shift > PRW'(BINS - 1)) ? BW'(BINS - 1) : lvl_shift[BW-1:0];
  assign suffix    = total_q - acc_q;
  assign dsh       = RW'(total_q) << k_q;
  assign grid      = (gs_q != '0) && (gcnt_q == '0);
  assign emit      = !grid && (row_q != sr_rdata) && (n_q < N_MAX);

  always_comb begin
    state_d = state_q;
    idx_d = idx_q;
    i_d = i_q;
    j_d = j_q;
    k_d = k_q;
    per_d = per_q;
    acc_d = acc_q;
    total_d = total_q;
    rem_d = rem_q;
    q_d = q_q;
    row_d = row_q;
    cur_old_d = cur_old_q;
    gcnt_d = gcnt_q;
    n_d = n_q;
    addr_d = addr_q;
    pend_valid_d = pend_valid_q;
    pend_col_d = pend_col_q;
    pend_old_d = pend_old_q;
    pend_new_d = pend_new_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_col_d = out_col_q;
    out_old_d = out_old_q;
    out_new_d = out_new_q;
    out_last_d = out_last_q;
    bin_we = 1'b0;
    bin_waddr = idx_q[AW-1:0];
    bin_wdata = '0;
    bin_raddr = idx_q[AW-1:0];
    sr_we = 1'b0;
    sr_waddr = i_q[BW-1:0];
    sr_wdata = row_q;
    q_next = q_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          priority if (in_i.mode == swhc_pkg::MODE_CLEAR) begin
            idx_d = '0;
            per_d = '0;
            state_d = ST_CLR;
          end else if (en_q && in_i.mode == swhc_pkg::MODE_SAMPLE) begin
            addr_d = per_base + AW'(smp_bin);
            state_d = ST_SMP_RD;
          end else if (en_q && in_i.mode == swhc_pkg::MODE_TICK) begin
            idx_d = '0;
            acc_d = '0;
            state_d = ST_TOT_RD;
          end
        end
      end
      ST_INIT, ST_CLR: begin
        bin_we = 1'b1;
        if (state_q == ST_INIT && idx_q < IW'(BINS)) begin
          sr_we = 1'b1;
          sr_waddr = idx_q[BW-1:0];
          sr_wdata = '0;
        end
        if (idx_q == NE_LAST) begin
          state_d = ST_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_SMP_RD: begin
        bin_raddr = addr_q;
        state_d = ST_SMP_WR;
      end
      ST_SMP_WR: begin
        bin_we = 1'b1;
        bin_waddr = addr_q;
        bin_wdata = (bin_rdata == '1) ? bin_rdata : bin_rdata + 1'b1;
        state_d = ST_IDLE;
      end
      ST_TOT_RD: begin
        state_d = ST_TOT_ACC;
      end
      ST_TOT_ACC: begin
        if (idx_q == NE_LAST) begin
          total_d = acc_q + CW'(bin_rdata);
          acc_d = '0;
          i_d = '0;
          j_d = '0;
          gcnt_d = '0;
          n_d = '0;
          state_d = ST_COL;
        end else begin
          acc_d = acc_q + CW'(bin_rdata);
          idx_d = idx_q + 1'b1;
          state_d = ST_TOT_RD;
        end
      end
      ST_COL: begin
        if (total_q == '0) begin
          row_d = h_q;
          state_d = ST_SR_RD;
        end else begin
          rem_d = RW'(h_q) * RW'(suffix);
          q_d = '0;
          k_d = 3'd7;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (rem_q >= dsh) begin
          rem_d = rem_q - dsh;
          q_next = q_q | (RWW'(1) << k_q);
        end
        q_d = q_next;
        if (k_q == 3'd0) begin
          row_d = h_q - q_next;
          state_d = ST_SR_RD;
        end else begin
          k_d = k_q - 1'b1;
        end
      end
      ST_SR_RD: begin
        state_d = ST_SR_CMP;
      end
      ST_SR_CMP: begin
        j_d = '0;
        state_d = ST_PRE_RD;
        if (emit) begin
          sr_we = 1'b1;
          n_d = n_q + 1'b1;
          cur_old_d = sr_rdata;
          if (pend_valid_q) begin
            state_d = ST_PUSH;
          end else begin
            pend_valid_d = 1'b1;
            pend_col_d = i_q[COW-1:0];
            pend_old_d = sr_rdata;
            pend_new_d = row_q;
          end
        end
      end
      ST_PUSH: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_col_d = pend_col_q;
          out_old_d = pend_old_q;
          out_new_d = pend_new_q;
          out_last_d = 1'b0;
          pend_col_d = i_q[COW-1:0];
          pend_old_d = cur_old_q;
          pend_new_d = row_q;
          state_d = ST_PRE_RD;
        end
      end
      ST_PRE_RD: begin
        bin_raddr = pre_addr;
        state_d = ST_PRE_ACC;
      end
      ST_PRE_ACC: begin
        acc_d = acc_q + CW'(bin_rdata);
        if (j_q == PER_LAST) begin
          gcnt_d = (gcnt_q == gs_q - 1'b1) ? '0 : gcnt_q + 1'b1;
          if (i_q == BIN_LAST) begin
            state_d = ST_FLUSH;
          end else begin
            i_d = i_q + 1'b1;
            state_d = ST_COL;
          end
        end else begin
          j_d = j_q + 1'b1;
          state_d = ST_PRE_RD;
        end
      end
      ST_FLUSH: begin
        if (!pend_valid_q || slot_free) begin
          if (pend_valid_q) begin
            out_valid_d = 1'b1;
            out_col_d = pend_col_q;
            out_old_d = pend_old_q;
            out_new_d = pend_new_q;
            out_last_d = 1'b1;
          end
          pend_valid_d = 1'b0;
          per_d = (per_q == PQ_LAST) ? '0 : per_q + 1'b1;
          i_d = '0;
          state_d = ST_PCLR;
        end
      end
      ST_PCLR: begin
        bin_we = 1'b1;
        bin_waddr = pclr_addr;
        if (i_q == BIN_LAST) begin
          state_d = ST_IDLE;
        end else begin
          i_d = i_q + 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      idx_q <= '0;
      i_q <= '0;
      j_q <= '0;
      k_q <= '0;
      per_q <= '0;
      gcnt_q <= '0;
      n_q <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      en_q <= 1'b0;
      h_q <= swhc_pkg::HEIGHT_RST;
      gs_q <= swhc_pkg::GRIDLINE_RST;
    end else begin
      state_q <= state_d;
      idx_q <= idx_d;
      i_q <= i_d;
      j_q <= j_d;
      k_q <= k_d;
      per_q <= per_d;
      gcnt_q <= gcnt_d;
      n_q <= n_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          swhc_pkg::CFG_ENABLED:  en_q <= cfg_data_i[0];
          swhc_pkg::CFG_HEIGHT:   h_q <= cfg_data_i;
          swhc_pkg::CFG_GRIDLINE: gs_q <= cfg_data_i[swhc_pkg::GRID_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    total_q <= total_d;
    rem_q <= rem_d;
    q_q <= q_d;
    row_q <= row_d;
    cur_old_q <= cur_old_d;
    addr_q <= addr_d;
    pend_col_q <= pend_col_d;
    pend_old_q <= pend_old_d;
    pend_new_q <= pend_new_d;
    out_col_q <= out_col_d;
    out_old_q <= out_old_d;
    out_new_q <= out_new_d;
    out_last_q <= out_last_d;
  end

  swhc_ram #(
    .WIDTH(CTW),
    .DEPTH(NE)
  ) u_bin_ram (
    .clk_i  (clk_i),
    .we_i   (bin_we),
    .waddr_i(bin_waddr),
    .wdata_i(bin_wdata),
    .raddr_i(bin_raddr),
    .rdata_o(bin_rdata)
  );

  swhc_ram #(
    .WIDTH(RWW),
    .DEPTH(BINS)
  ) u_row_ram (
    .clk_i  (clk_i),
    .we_i   (sr_we),
    .waddr_i(sr_waddr),
    .wdata_i(sr_wdata),
    .raddr_i(i_q[BW-1:0]),
    .rdata_o(sr_rdata)
  );

  assign out_o.valid   = out_valid_q;
  assign out_o.column  = out_col_q;
  assign out_o.old_row = out_old_q;
  assign out_o.new_row = out_new_q;
  assign out_o.last    = out_last_q;

  `SWHC_ASSERT(a_result_limit, n_q <= N_MAX, "result count above limit")
  `SWHC_ASSERT(a_pend_flushed, pend_valid_q |-> state_q != ST_IDLE, "pending beat left at idle")
  `SWHC_ASSERT(a_quot_range, state_q == ST_SR_RD |-> row_q <= h_q, "row above plot height")

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// checks the sliding window histogram core against a cycle-free predictor of
// its bins, window, ccdf rows and result beats, across register settings,
// random sender gaps and receiver stalls, including a long receiver hold-off
// ---------------------------------------------------------------------------
module tb;
  import swhc_pkg::*;

  localparam int NBINS      = BINS_DEF;
  localparam int NPERIODS   = WINDOW_PERIODS_DEF;
  localparam int QUIET_CYC  = 4000;
  localparam int CYCLE_LIMIT = 1500000;

  typedef struct {
    logic [MODE_W-1:0]  mode;
    logic [LEVEL_W-1:0] level;
  } hist_item_t;

  typedef struct {
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] old_row;
    logic [ROW_W-1:0] new_row;
    logic             last;
  } row_update_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  swhc_in_if  in_if ();
  swhc_out_if out_if ();

  sliding_window_histogram_ccdf_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always #1 clk_i = ~clk_i;

  // predictor state
  logic [COUNT_W-1:0] hist_counts [NPERIODS][NBINS];
  logic [ROW_W-1:0]   plotted_rows [NBINS];
  int                 period_idx;
  logic               cfg_enabled;
  logic [ROW_W-1:0]   cfg_height;
  logic [GRID_W-1:0]  cfg_grid;

  hist_item_t  pending_items [$];
  row_update_t expected_rows [$];
  int          error_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  logic        recv_hold = 1'b0;
  int          cycle_count = 0;

  task automatic report(input string what);
    error_count++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  function automatic void clear_window();
    for (int p = 0; p < NPERIODS; p++)
      for (int b = 0; b < NBINS; b++) hist_counts[p][b] = '0;
    period_idx = 0;
  endfunction

  function automatic void predict_tick();
    longint unsigned sums [NBINS];
    longint unsigned total, h, row;
    row_update_t     upd;
    row_update_t     beats [$];
    bit              grid;
    h = cfg_height;
    for (int b = 0; b < NBINS; b++) begin
      sums[b] = 0;
      for (int p = 0; p < NPERIODS; p++) sums[b] += hist_counts[p][b];
    end
    for (int b = NBINS - 2; b >= 0; b--) sums[b] += sums[b+1];
    total = sums[0];
    for (int b = 0; b < NBINS; b++) begin
      row = (total == 0) ? h : h - (h * sums[b]) / total;
      grid = (cfg_grid != 0) && ((b % cfg_grid) == 0);
      if (!grid && row[ROW_W-1:0] != plotted_rows[b] && beats.size() < MAX_RESULTS) begin
        upd.column = b[COL_W-1:0];
        upd.old_row = plotted_rows[b];
        upd.new_row = row[ROW_W-1:0];
        upd.last = 1'b0;
        plotted_rows[b] = row[ROW_W-1:0];
        beats.push_back(upd);
      end
    end
    if (beats.size() > 0) beats[beats.size()-1].last = 1'b1;
    foreach (beats[k]) expected_rows.push_back(beats[k]);
    period_idx = (period_idx + 1) % NPERIODS;
    for (int b = 0; b < NBINS; b++) hist_counts[period_idx][b] = '0;
  endfunction

  function automatic void predict_item(input hist_item_t it);
    longint unsigned bin;
    if (it.mode == MODE_CLEAR) begin
      clear_window();
    end else if (cfg_enabled) begin
      if (it.mode == MODE_SAMPLE) begin
        bin = (longint'(it.level) * NBINS) >> 16;
        if (bin > NBINS - 1) bin = NBINS - 1;
        if (hist_counts[period_idx][bin] != '1)
          hist_counts[period_idx][bin] = hist_counts[period_idx][bin] + 1'b1;
      end else if (it.mode == MODE_TICK) begin
        predict_tick();
      end
    end
  endfunction

  // driver
  always @(posedge clk_i) begin
    hist_hold_dummy: begin end
    if (in_if.valid && in_if.ready) begin
      predict_item(pending_items[0]);
      void'(pending_items.pop_front());
    end
    if ((in_if.valid && !in_if.ready) ||
        (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct)) begin
      in_if.valid <= 1'b1;
      in_if.mode <= pending_items[0].mode;
      in_if.sample_level <= pending_items[0].level;
    end else begin
      in_if.valid <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    row_update_t exp_row;
    if (out_if.valid && out_if.ready) begin
      if (expected_rows.size() == 0) begin
        report($sformatf("unexpected beat column %0d", out_if.column));
      end else begin
        exp_row = expected_rows.pop_front();
        if (out_if.column !== exp_row.column)
          report($sformatf("column %0d, want %0d", out_if.column, exp_row.column));
        if (out_if.old_row !== exp_row.old_row)
          report($sformatf("old_row %0d, want %0d (column %0d)", out_if.old_row,
                           exp_row.old_row, exp_row.column));
        if (out_if.new_row !== exp_row.new_row)
          report($sformatf("new_row %0d, want %0d (column %0d)", out_if.new_row,
                           exp_row.new_row, exp_row.column));
        if (out_if.last !== exp_row.last)
          report($sformatf("last %0b, want %0b (column %0d)", out_if.last,
                           exp_row.last, exp_row.column));
      end
    end
    out_if.ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value[CFG_DATA_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_ENABLED:  cfg_enabled = value[0];
      CFG_HEIGHT:   cfg_height = value[ROW_W-1:0];
      CFG_GRIDLINE: cfg_grid = value[GRID_W-1:0];
      default: begin end
    endcase
  endtask

  task automatic push_item(input logic [MODE_W-1:0] mode, input int level);
    hist_item_t it;
    it.mode = mode;
    it.level = level[LEVEL_W-1:0];
    @(negedge clk_i);
    pending_items.push_back(it);
  endtask

  task automatic wait_idle();
    while (pending_items.size() > 0 || in_if.valid || expected_rows.size() > 0)
      @(posedge clk_i);
    repeat (QUIET_CYC) @(posedge clk_i);
  endtask

  task automatic random_burst(input int n_items);
    int sent;
    int burst;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(19))
        0: push_item(MODE_CLEAR, $urandom);
        1: push_item(2'd3, $urandom);
        default: begin
          burst = $urandom_range(10);
          for (int k = 0; k < burst; k++) begin
            if ($urandom_range(3) == 0) push_item(MODE_SAMPLE, $urandom_range(131071));
            else push_item(MODE_SAMPLE, $urandom_range(65535 >> $urandom_range(4)));
          end
          sent += burst;
          push_item(MODE_TICK, $urandom);
        end
      endcase
      sent++;
    end
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.mode = MODE_SAMPLE;
    in_if.sample_level = '0;
    out_if.ready = 1'b0;
    clear_window();
    for (int b = 0; b < NBINS; b++) plotted_rows[b] = '0;
    cfg_enabled = 1'b0;
    cfg_height = HEIGHT_RST;
    cfg_grid = GRIDLINE_RST;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // disabled: sample and tick ignored, clear still acts
    push_item(MODE_SAMPLE, 1024);
    push_item(MODE_TICK, 0);
    push_item(MODE_CLEAR, 0);
    push_item(2'd3, 131071);
    wait_idle();

    write_reg(CFG_ENABLED, 1);
    push_item(MODE_TICK, 0);
    push_item(MODE_SAMPLE, 0);
    push_item(MODE_SAMPLE, 1023);
    push_item(MODE_SAMPLE, 1024);
    push_item(MODE_SAMPLE, 65535);
    push_item(MODE_SAMPLE, 65536);
    push_item(MODE_SAMPLE, 131071);
    push_item(MODE_SAMPLE, 'h15555);
    push_item(MODE_SAMPLE, 'h0AAAA);
    push_item(2'd3, 'h1FFFF);
    push_item(MODE_TICK, 'h1FFFF);
    push_item(MODE_SAMPLE, 40000);
    push_item(MODE_TICK, 0);
    push_item(MODE_CLEAR, 0);
    push_item(MODE_TICK, 0);
    wait_idle();

    write_reg(CFG_HEIGHT, 255);
    write_reg(CFG_GRIDLINE, 0);
    push_item(MODE_SAMPLE, 500);
    push_item(MODE_TICK, 0);
    for (int k = 0; k < NPERIODS + 1; k++) push_item(MODE_TICK, 0);
    random_burst(60);
    wait_idle();

    write_reg(CFG_HEIGHT, 1);
    write_reg(CFG_GRIDLINE, 1);
    send_idle_pct = 45;
    random_burst(50);
    wait_idle();

    write_reg(CFG_HEIGHT, 0);
    write_reg(CFG_GRIDLINE, 127);
    send_idle_pct = 0;
    recv_stall_pct = 45;
    @(posedge clk_i);
    recv_hold <= 1'b1;
    fork
      begin
        repeat (20000) @(posedge clk_i);
        recv_hold <= 1'b0;
      end
    join_none
    push_item(MODE_CLEAR, 0);
    random_burst(55);
    wait_idle();

    write_reg(CFG_HEIGHT, 219);
    write_reg(CFG_GRIDLINE, 64);
    send_idle_pct = 33;
    recv_stall_pct = 33;
    random_burst(50);
    wait_idle();

    write_reg(CFG_GRIDLINE, 16);
    write_reg(CFG_ENABLED, 0);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    push_item(MODE_SAMPLE, 3000);
    push_item(MODE_TICK, 0);
    push_item(MODE_CLEAR, 0);
    wait_idle();
    write_reg(CFG_ENABLED, 1);
    random_burst(30);
    wait_idle();

    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
